/* hw/rtl/tbd_pkg.sv */
// Package for the BOM-detecting Unicode decoder: types, constants and the
// per-byte UTF-8 and per-unit UTF-16 step functions.
// Depends on nothing; used by text_bom_detect_unicode_decoder_unit.
`timescale 1ns / 1ps
`default_nettype none

package tbd_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int COUNT_W = PTR_W + 1;

	localparam logic [7:0] BOM_FE = 8'hFE;
	localparam logic [7:0] BOM_FF = 8'hFF;

	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_CODE = 8'h80;

	localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_SURR_LAST = 16'hDBFF;
	localparam logic [15:0] LOW_SURR_FIRST = 16'hDC00;
	localparam logic [15:0] LOW_SURR_LAST = 16'hDFFF;
	localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

	typedef enum logic [1:0] {
		MODE_DETECT = 2'd0,
		MODE_UTF8 = 2'd1,
		MODE_BE = 2'd2,
		MODE_LE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_CHAR = 2'd0,
		ST_NUL = 2'd1,
		ST_MALFORMED = 2'd2
	} status_t;

	typedef struct packed {
		logic [20:0] code_point;
		status_t status;
		logic last;
	} result_t;

	typedef struct packed {
		logic emit;
		logic halt;
		logic [20:0] code_point;
		status_t status;
	} emit_t;

	typedef struct packed {
		logic [20:0] partial;
		logic [1:0] remaining;
		emit_t res;
	} utf8_step_t;

	typedef struct packed {
		logic pending;
		logic [9:0] high;
		emit_t res;
	} utf16_step_t;

	function automatic emit_t no_emit();
		emit_t e;
		e.emit = 1'b0;
		e.halt = 1'b0;
		e.code_point = '0;
		e.status = ST_CHAR;
		return e;
	endfunction

	function automatic emit_t deliver(input logic [20:0] v);
		emit_t e;
		e.emit = 1'b1;
		if (v == '0) begin
			e.halt = 1'b1;
			e.code_point = '0;
			e.status = ST_NUL;
		end else begin
			e.halt = 1'b0;
			e.code_point = v;
			e.status = ST_CHAR;
		end
		return e;
	endfunction

	function automatic emit_t malformed();
		emit_t e;
		e.emit = 1'b1;
		e.halt = 1'b1;
		e.code_point = '0;
		e.status = ST_MALFORMED;
		return e;
	endfunction

	function automatic utf8_step_t utf8_step(input logic [20:0] partial,
			input logic [1:0] remaining, input logic [7:0] b);
		utf8_step_t r;
		logic [20:0] shifted;
		r.partial = partial;
		r.remaining = remaining;
		r.res = no_emit();
		shifted = {partial[14:0], b[5:0]};
		if (remaining == 2'd0) begin
			if ((b & LEAD2_MASK) == LEAD2_CODE) begin
				r.partial = {16'd0, b[4:0]};
				r.remaining = 2'd1;
			end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
				r.partial = {17'd0, b[3:0]};
				r.remaining = 2'd2;
			end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
				r.partial = {18'd0, b[2:0]};
				r.remaining = 2'd3;
			end else begin
				r.res = deliver({13'd0, b});
			end
		end else if ((b & CONT_MASK) != CONT_CODE) begin
			r.remaining = 2'd0;
			r.res = malformed();
		end else begin
			r.partial = shifted;
			r.remaining = remaining - 2'd1;
			if (remaining == 2'd1) begin
				r.res = deliver(shifted);
			end
		end
		return r;
	endfunction

	function automatic utf16_step_t utf16_step(input logic pending,
			input logic [9:0] high, input logic [15:0] u);
		utf16_step_t r;
		r.pending = pending;
		r.high = high;
		r.res = no_emit();
		if (pending) begin
			r.pending = 1'b0;
			if (u < LOW_SURR_FIRST || u > LOW_SURR_LAST) begin
				r.res = malformed();
			end else begin
				r.res = deliver({1'b0, high, u[9:0]} + SUPPLEMENTARY_BASE);
			end
		end else if (u >= HIGH_SURR_FIRST && u <= HIGH_SURR_LAST) begin
			r.high = u[9:0];
			r.pending = 1'b1;
		end else begin
			r.res = deliver({5'd0, u});
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/text_bom_detect_unicode_decoder_unit.sv */
// Top level of the BOM-detecting Unicode decoder: input register, decode
// logic and a four-entry result queue. Depends on tbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one byte per cycle and gives Unicode code points on the
// output channel. The first two bytes choose UTF-16BE, UTF-16LE or UTF-8; a
// byte-order mark is consumed, and for UTF-8 both held bytes are decoded in
// one step, which can give two results from a single beat. A byte is held in
// an input register, decoded from there and written into a four-entry result
// queue, from which the output channel is driven. The sustained rate is one
// byte per cycle, set by the decode step and the one-result-per-cycle output
// queue; input stalls only while the queue holds three or more results. A NUL
// code point or a malformed sequence is reported and then every further byte
// is taken and dropped until reset.
module text_bom_detect_unicode_decoder_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] data_byte,
	output logic out_valid,
	input wire logic out_ready,
	output logic [20:0] code_point,
	output logic [1:0] status,
	output logic last
);

	logic valid_s1;
	logic [7:0] data_s1;
	logic process;

	tbd_pkg::mode_t mode_q, mode_d;
	logic [7:0] held_byte_q, held_byte_d;
	logic held_valid_q, held_valid_d;
	logic [20:0] partial_q, partial_d;
	logic [1:0] remaining_q, remaining_d;
	logic [9:0] high_half_q, high_half_d;
	logic pair_pending_q, pair_pending_d;
	logic halted_q, halted_d;

	tbd_pkg::utf8_step_t u8_first, u8_second, u8_direct;
	tbd_pkg::utf16_step_t u16_be, u16_le;
	tbd_pkg::emit_t emit0, emit1;
	tbd_pkg::result_t res0, res1;
	logic [1:0] push_n;

	tbd_pkg::result_t fifo_q [tbd_pkg::FIFO_DEPTH];
	logic [tbd_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [tbd_pkg::COUNT_W-1:0] count_q;
	logic pop;

	assign process = valid_s1 && (count_q <= tbd_pkg::COUNT_W'(tbd_pkg::FIFO_DEPTH - 2));
	assign in_ready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
		end
	end

	assign u8_direct = tbd_pkg::utf8_step(partial_q, remaining_q, data_s1);
	assign u8_first = tbd_pkg::utf8_step(partial_q, remaining_q, held_byte_q);
	assign u8_second = tbd_pkg::utf8_step(u8_first.partial, u8_first.remaining, data_s1);
	assign u16_be = tbd_pkg::utf16_step(pair_pending_q, high_half_q, {held_byte_q, data_s1});
	assign u16_le = tbd_pkg::utf16_step(pair_pending_q, high_half_q, {data_s1, held_byte_q});

	always_comb begin
		mode_d = mode_q;
		held_byte_d = held_byte_q;
		held_valid_d = held_valid_q;
		partial_d = partial_q;
		remaining_d = remaining_q;
		high_half_d = high_half_q;
		pair_pending_d = pair_pending_q;
		emit0 = tbd_pkg::no_emit();
		emit1 = tbd_pkg::no_emit();
		if (!halted_q) begin
			case (mode_q)
				tbd_pkg::MODE_DETECT: begin
					if (!held_valid_q) begin
						held_byte_d = data_s1;
						held_valid_d = 1'b1;
					end else begin
						held_byte_d = '0;
						held_valid_d = 1'b0;
						if (held_byte_q == tbd_pkg::BOM_FE && data_s1 == tbd_pkg::BOM_FF) begin
							mode_d = tbd_pkg::MODE_BE;
						end else if (held_byte_q == tbd_pkg::BOM_FF
								&& data_s1 == tbd_pkg::BOM_FE) begin
							mode_d = tbd_pkg::MODE_LE;
						end else if (held_byte_q == '0 && data_s1 != '0) begin
							mode_d = tbd_pkg::MODE_BE;
							pair_pending_d = u16_be.pending;
							high_half_d = u16_be.high;
							emit0 = u16_be.res;
						end else if (held_byte_q != '0 && data_s1 == '0) begin
							mode_d = tbd_pkg::MODE_LE;
							pair_pending_d = u16_le.pending;
							high_half_d = u16_le.high;
							emit0 = u16_le.res;
						end else begin
							mode_d = tbd_pkg::MODE_UTF8;
							emit0 = u8_first.res;
							if (u8_first.res.halt) begin
								partial_d = u8_first.partial;
								remaining_d = u8_first.remaining;
							end else begin
								partial_d = u8_second.partial;
								remaining_d = u8_second.remaining;
								emit1 = u8_second.res;
							end
						end
					end
				end
				tbd_pkg::MODE_UTF8: begin
					partial_d = u8_direct.partial;
					remaining_d = u8_direct.remaining;
					emit0 = u8_direct.res;
				end
				tbd_pkg::MODE_BE, tbd_pkg::MODE_LE: begin
					if (!held_valid_q) begin
						held_byte_d = data_s1;
						held_valid_d = 1'b1;
					end else begin
						held_byte_d = '0;
						held_valid_d = 1'b0;
						if (mode_q == tbd_pkg::MODE_BE) begin
							pair_pending_d = u16_be.pending;
							high_half_d = u16_be.high;
							emit0 = u16_be.res;
						end else begin
							pair_pending_d = u16_le.pending;
							high_half_d = u16_le.high;
							emit0 = u16_le.res;
						end
					end
				end
				default: begin
					mode_d = mode_q;
				end
			endcase
		end
		halted_d = halted_q || emit0.halt || emit1.halt;
	end

	// Compact the up to two results of this byte and mark the final one.
	always_comb begin
		res0.code_point = emit0.code_point;
		res0.status = emit0.status;
		res0.last = 1'b0;
		res1.code_point = emit1.code_point;
		res1.status = emit1.status;
		res1.last = 1'b1;
		push_n = 2'd0;
		if (emit0.emit && emit1.emit) begin
			push_n = 2'd2;
		end else if (emit0.emit) begin
			push_n = 2'd1;
			res0.last = 1'b1;
		end else if (emit1.emit) begin
			push_n = 2'd1;
			res0.code_point = emit1.code_point;
			res0.status = emit1.status;
			res0.last = 1'b1;
		end
		if (!process) begin
			push_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tbd_pkg::MODE_DETECT;
			held_byte_q <= '0;
			held_valid_q <= 1'b0;
			partial_q <= '0;
			remaining_q <= '0;
			high_half_q <= '0;
			pair_pending_q <= 1'b0;
			halted_q <= 1'b0;
		end else if (process) begin
			mode_q <= mode_d;
			held_byte_q <= held_byte_d;
			held_valid_q <= held_valid_d;
			partial_q <= partial_d;
			remaining_q <= remaining_d;
			high_half_q <= high_half_d;
			pair_pending_q <= pair_pending_d;
			halted_q <= halted_d;
		end
	end

	assign out_valid = (count_q != '0);
	assign pop = out_valid && out_ready;
	assign code_point = fifo_q[rd_ptr_q].code_point;
	assign status = fifo_q[rd_ptr_q].status;
	assign last = fifo_q[rd_ptr_q].last;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_ptr_q + tbd_pkg::PTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + tbd_pkg::PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tbd_pkg::PTR_W'(1);
			end
			count_q <= count_q + tbd_pkg::COUNT_W'(push_n) - tbd_pkg::COUNT_W'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tbd_pkg::COUNT_W'(tbd_pkg::FIFO_DEPTH))
		else $error("result queue holds more beats than its depth");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted state cleared without reset");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> push_n == 2'd0)
		else $error("result produced while halted");

	a_pair_in_utf16: assert property (@(posedge clk) disable iff (!arst_n)
		pair_pending_q |-> (mode_q == tbd_pkg::MODE_BE || mode_q == tbd_pkg::MODE_LE))
		else $error("surrogate pair pending outside UTF-16 mode");

	a_double_only_on_replay: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> mode_q == tbd_pkg::MODE_DETECT)
		else $error("two results from one beat outside detection");
`endif

endmodule

`default_nettype wire
